// File: src/aes_encrypt_round_macros.svh
// assertion macros shared by the aes round rtl
`ifndef AES_ENCRYPT_ROUND_MACROS_SVH
`define AES_ENCRYPT_ROUND_MACROS_SVH

// same-cycle implication, checked out of reset
`define AER_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked out of reset
`define AER_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// File: src/aes_er_pkg.sv
// types, s-box and mixcolumns helpers for the aes encryption round
package aes_er_pkg;

    localparam int NUM_COLS = 4;
    localparam int COL_W    = 32;

    typedef logic [COL_W-1:0]               t_col;
    typedef logic [NUM_COLS-1:0][COL_W-1:0] t_block;

    localparam logic [7:0] XTIME_POLY = 8'h1B;

    localparam logic [7:0] SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,
        8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,
        8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,
        8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,
        8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,
        8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,
        8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,
        8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,
        8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,
        8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,
        8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,
        8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,
        8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,
        8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,
        8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,
        8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,
        8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    // multiply by 2 in gf(2^8) mod 0x11b
    function automatic logic [7:0] xtime(input logic [7:0] v);
        xtime = {v[6:0], 1'b0} ^ (v[7] ? XTIME_POLY : 8'h00);
    endfunction

    // one column through the {2,3,1,1} circulant matrix
    function automatic t_col mix_col(input t_col a);
        logic [7:0] a0, a1, a2, a3;
        logic [7:0] m0, m1, m2, m3;
        a0 = a[31:24];
        a1 = a[23:16];
        a2 = a[15:8];
        a3 = a[7:0];
        m0 = xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3;
        m1 = a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3;
        m2 = a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3;
        m3 = xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3);
        mix_col = {m0, m1, m2, m3};
    endfunction

endpackage

// File: src/aes_encrypt_round.sv
// One AES-128 encryption round: SubBytes, ShiftRows, MixColumns, AddRoundKey.
// Input channel: i_valid / o_stall carries four state columns and four round
// key columns; a transfer happens on a rising edge with i_valid high and
// o_stall low. Row 0 of each column sits in bits 31:24.
// Output channel: o_valid / i_stall carries the four result columns; a
// transfer happens on a rising edge with o_valid high and i_stall low.
// A block passes an input register, then the whole round as s-box lookups
// and xor trees into the result register, which drives o_valid.
// Throughput is one block per cycle while the receiver does not stall; the
// single round datapath between the two registers sets that figure.
// When the receiver stalls, the result register holds and the input register
// still takes one more block; o_stall rises only once both are full.
// Reset (i_rst_n low, synchronous) empties both registers; no state is kept
// between blocks.
`include "aes_encrypt_round_macros.svh"

module aes_encrypt_round
    import aes_er_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_stall,
    input  t_col i_state_col0,
    input  t_col i_state_col1,
    input  t_col i_state_col2,
    input  t_col i_state_col3,
    input  t_col i_key_col0,
    input  t_col i_key_col1,
    input  t_col i_key_col2,
    input  t_col i_key_col3,
    output logic o_valid,
    input  logic i_stall,
    output t_col o_out_col0,
    output t_col o_out_col1,
    output t_col o_out_col2,
    output t_col o_out_col3
);

    logic   r_in_valid;
    t_block r_state;
    t_block r_key;
    logic   r_out_valid;
    t_block r_out;

    logic   out_move;
    logic   in_move;
    t_block shifted;
    t_block n_out;

    assign out_move = !r_out_valid || !i_stall;
    assign in_move  = !r_in_valid || out_move;
    assign o_stall  = !in_move;

    // subbytes and shiftrows: row r of column c comes from column c + r
    always_comb begin
        for (int c = 0; c < NUM_COLS; c++) begin
            for (int r = 0; r < 4; r++) begin
                shifted[c][31 - 8*r -: 8] =
                    SBOX[r_state[2'((c + r) & 3)][31 - 8*r -: 8]];
            end
        end
    end

    always_comb begin
        for (int c = 0; c < NUM_COLS; c++) begin
            n_out[c] = mix_col(shifted[c]) ^ r_key[c];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_move) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_move && i_valid) begin
            r_state <= {i_state_col3, i_state_col2, i_state_col1, i_state_col0};
            r_key   <= {i_key_col3, i_key_col2, i_key_col1, i_key_col0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_move) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_move && r_in_valid) begin
            r_out <= n_out;
        end
    end

    assign o_valid    = r_out_valid;
    assign o_out_col0 = r_out[0];
    assign o_out_col1 = r_out[1];
    assign o_out_col2 = r_out[2];
    assign o_out_col3 = r_out[3];

    `AER_ASSERT_NOW(a_stall_only_when_full, o_stall, r_in_valid && r_out_valid, "stall with room left")
    `AER_ASSERT_NEXT(a_accept_lands, i_valid && !o_stall, r_in_valid, "accepted block not held")
    `AER_ASSERT_NEXT(a_advance_to_out, r_in_valid && out_move, r_out_valid, "block lost between stages")
    `AER_ASSERT_NEXT(a_held_input_stable, r_in_valid && o_stall, $stable(r_state) && $stable(r_key), "held block changed")

endmodule
